// File: design/slipc_pkg.sv
// Shared types and constants for the sorted insertion priority queue.
package slipc_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int ENTRY_COUNT_W = 5;
    localparam int STATUS_W      = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SHIFT,
        ST_PLACE
    } state_t;

    // write address: ring head, or one past the entry under compare
    typedef enum logic {
        WA_HEAD,
        WA_KP1
    } wr_addr_sel_t;

    typedef enum logic [1:0] {
        WD_IN,
        WD_VAL,
        WD_RDATA
    } wr_data_sel_t;

    typedef enum logic [1:0] {
        RA_HEAD,
        RA_TAIL,
        RA_KM1
    } rd_addr_sel_t;

    typedef struct packed {
        logic         load_item;
        logic         wr_en;
        wr_addr_sel_t wr_addr_sel;
        wr_data_sel_t wr_data_sel;
        logic         rd_en;
        rd_addr_sel_t rd_addr_sel;
        logic         k_load;
        logic         k_dec;
        logic         head_inc;
        logic         count_inc;
        logic         count_dec;
        logic         res_load;
        logic         res_pop;
        status_t      res_status;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic k_zero;
        logic greater;
    } dp_stat_t;

endpackage

// File: design/slipc_dp.sv
// Datapath: ring-addressed sorted store, pointers, count and result register.
module slipc_dp #(
    parameter int DEPTH = slipc_pkg::DEPTH_DEFAULT
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic signed [slipc_pkg::VALUE_W-1:0]     in_value,
    input  slipc_pkg::dp_cmd_t                       cmd,
    output slipc_pkg::dp_stat_t                      stat,
    output logic signed [slipc_pkg::VALUE_W-1:0]     res_value,
    output logic [slipc_pkg::ENTRY_COUNT_W-1:0]      res_count,
    output slipc_pkg::status_t                       res_status
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int MEM_LEN = 1 << AW;

    logic signed [slipc_pkg::VALUE_W-1:0] mem [MEM_LEN];

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] k_reg, k_next;
    logic signed [slipc_pkg::VALUE_W-1:0] val_reg;
    logic signed [slipc_pkg::VALUE_W-1:0] rdata_reg;
    logic signed [slipc_pkg::VALUE_W-1:0] res_value_reg;
    logic [slipc_pkg::ENTRY_COUNT_W-1:0]  res_count_reg;
    slipc_pkg::status_t                   res_status_reg;

    logic [AW-1:0] wr_addr, rd_addr, tail_off;
    logic signed [slipc_pkg::VALUE_W-1:0] wr_data;

    assign tail_off = AW'(count_reg - CW'(1));

    always_comb begin
        unique case (cmd.wr_addr_sel)
            slipc_pkg::WA_HEAD: wr_addr = head_reg;
            slipc_pkg::WA_KP1:  wr_addr = head_reg + k_reg + AW'(1);
            default:            wr_addr = head_reg;
        endcase
        unique case (cmd.wr_data_sel)
            slipc_pkg::WD_IN:    wr_data = in_value;
            slipc_pkg::WD_VAL:   wr_data = val_reg;
            slipc_pkg::WD_RDATA: wr_data = rdata_reg;
            default:             wr_data = val_reg;
        endcase
        unique case (cmd.rd_addr_sel)
            slipc_pkg::RA_HEAD: rd_addr = head_reg;
            slipc_pkg::RA_TAIL: rd_addr = head_reg + tail_off;
            slipc_pkg::RA_KM1:  rd_addr = head_reg + k_reg - AW'(1);
            default:            rd_addr = head_reg;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.count_inc) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.count_dec) begin
            count_next = count_reg - CW'(1);
        end
        head_next = cmd.head_inc ? head_reg + AW'(1) : head_reg;
        k_next = k_reg;
        if (cmd.k_load) begin
            k_next = tail_off;
        end else if (cmd.k_dec) begin
            k_next = k_reg - AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            head_reg  <= '0;
        end else begin
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    // store and read port
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= k_next;
        if (cmd.load_item) begin
            val_reg <= in_value;
        end
        if (cmd.res_load) begin
            res_value_reg  <= cmd.res_pop ? rdata_reg : '0;
            res_count_reg  <= slipc_pkg::ENTRY_COUNT_W'(count_next);
            res_status_reg <= cmd.res_status;
        end
    end

    assign stat.count_zero = (count_reg == '0);
    assign stat.count_full = (count_reg == CW'(DEPTH));
    assign stat.k_zero     = (k_reg == '0);
    assign stat.greater    = (rdata_reg > val_reg);

    assign res_value  = res_value_reg;
    assign res_count  = res_count_reg;
    assign res_status = res_status_reg;

endmodule

// File: design/slipc_ctrl.sv
// Controller: sequences insert shifts and pops, owns the handshake.
module slipc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_cmd,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  slipc_pkg::dp_stat_t stat,
    output slipc_pkg::dp_cmd_t  cmd
);

    slipc_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    assign s_tready = (state_reg == slipc_pkg::ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= slipc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_status = slipc_pkg::STATUS_OK;
        unique case (state_reg)
            slipc_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd.load_item = 1'b1;
                    if (s_cmd == slipc_pkg::CMD_INSERT) begin
                        priority if (stat.count_full) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = slipc_pkg::STATUS_FULL;
                        end else if (stat.count_zero) begin
                            cmd.wr_en       = 1'b1;
                            cmd.wr_addr_sel = slipc_pkg::WA_HEAD;
                            cmd.wr_data_sel = slipc_pkg::WD_IN;
                            cmd.count_inc   = 1'b1;
                            cmd.res_load    = 1'b1;
                        end else begin
                            cmd.rd_en       = 1'b1;
                            cmd.rd_addr_sel = slipc_pkg::RA_TAIL;
                            cmd.k_load      = 1'b1;
                            state_next      = slipc_pkg::ST_SHIFT;
                        end
                    end else begin
                        if (stat.count_zero) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = slipc_pkg::STATUS_EMPTY;
                        end else begin
                            cmd.rd_en       = 1'b1;
                            cmd.rd_addr_sel = slipc_pkg::RA_HEAD;
                            state_next      = slipc_pkg::ST_POP;
                        end
                    end
                end
            end
            slipc_pkg::ST_POP: begin
                cmd.head_inc  = 1'b1;
                cmd.count_dec = 1'b1;
                cmd.res_load  = 1'b1;
                cmd.res_pop   = 1'b1;
                state_next    = slipc_pkg::ST_IDLE;
            end
            slipc_pkg::ST_SHIFT: begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = slipc_pkg::WA_KP1;
                if (stat.greater) begin
                    // move entry up one slot, keep walking toward head until the head entry is moved
                    cmd.wr_data_sel = slipc_pkg::WD_RDATA;
                    if (stat.k_zero) begin
                        state_next = slipc_pkg::ST_PLACE;
                    end else begin
                        cmd.rd_en       = 1'b1;
                        cmd.rd_addr_sel = slipc_pkg::RA_KM1;
                        cmd.k_dec       = 1'b1;
                    end
                end else begin
                    cmd.wr_data_sel = slipc_pkg::WD_VAL;
                    cmd.count_inc   = 1'b1;
                    cmd.res_load    = 1'b1;
                    state_next      = slipc_pkg::ST_IDLE;
                end
            end
            slipc_pkg::ST_PLACE: begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = slipc_pkg::WA_HEAD;
                cmd.wr_data_sel = slipc_pkg::WD_VAL;
                cmd.count_inc   = 1'b1;
                cmd.res_load    = 1'b1;
                state_next      = slipc_pkg::ST_IDLE;
            end
            default: begin
                state_next = slipc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.res_load) begin
            out_valid_next = 1'b1;
        end
    end

endmodule

// File: design/sorted_list_insert_pop_count.sv
// Top level: bounded sorted insertion priority queue with insert and pop.
// Full insert, empty pop and insert into an empty queue load the result on the transfer;
// a pop reads the head, then loads the result in ST_POP; any other insert reads the tail,
// moves each larger entry up one slot in ST_SHIFT, then ST_PLACE if the value lands at
// the front. One item at a time, bounded by the single read and write port of the store.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result.
module sorted_list_insert_pop_count #(
    parameter int DEPTH = slipc_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value (signed)
    input  logic [0:0]  s_tuser,   // [0] cmd: 0 insert, 1 pop
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] popped_value, [36:32] entry_count, [39:37] zero
    output logic [1:0]  m_tuser    // [1:0] status: 0 ok, 1 full, 2 empty
);

    slipc_pkg::dp_cmd_t  dp_cmd;
    slipc_pkg::dp_stat_t dp_stat;

    logic signed [slipc_pkg::VALUE_W-1:0]  res_value;
    logic [slipc_pkg::ENTRY_COUNT_W-1:0]   res_count;
    slipc_pkg::status_t                    res_status;

    // Sequencer: one item in flight. An insert walks from the tail toward the
    // head, moving each larger entry up one slot until the new value fits.
    slipc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    // Store kept as a ring: a pop advances the head pointer and moves no entries.
    slipc_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_value   (s_tdata),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .res_value  (res_value),
        .res_count  (res_count),
        .res_status (res_status)
    );

    assign m_tdata = {3'b000, res_count, res_value};
    assign m_tuser = res_status;

endmodule
